### hdl/free_page_range_allocator_unit_defines.svh
// assertion macros for the free page range allocator
// used by the top level only
`ifndef FREE_PAGE_RANGE_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_PAGE_RANGE_ALLOCATOR_UNIT_DEFINES_SVH

// assert that an implication holds on every clock edge out of reset
`define FPRA_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
        else $error(msg);

// assert that a condition is never true
`define FPRA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/fpra_pkg.sv
// shared types and codes for the free page range allocator
// no dependencies
`timescale 1ns / 1ps

package fpra_pkg;

    localparam int unsigned PAGE_NUMBER_BITS = 36;
    localparam int unsigned FIELD_BITS       = PAGE_NUMBER_BITS;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_ADD     = 2'd2;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PAGE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]            action;
        logic [FIELD_BITS-1:0] page_number;
        logic [FIELD_BITS-1:0] page_count;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] granted_page;
        logic [1:0]            status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_UP_RD,
        S_DOWN_RD,
        S_FREE_RD,
        S_HOLE_RD,
        S_ADD,
        S_REPLY
    } t_state;

endpackage

### hdl/free_page_range_allocator_unit.sv
// channel          | direction | handshake
// in  (t_in_item)  | input     | i_in_valid / o_in_stall
// out (t_out_item) | output    | o_out_valid / i_out_stall
// from take to result: allocate reads the current slot, searches up then down for a non-empty extent,
// grants from it in S_ALLOC_RD and replies; free scans the used slots, then S_HOLE_RD; add region S_ADD
// the unit goes back to idle between transactions; the extent memory has separate read and write ports
// after reset a clearing pass over every extent slot runs before items are taken
// a two-entry input queue and an output register let either side stall freely
// top level of the free page range allocator
// depends on fpra_pkg, fpra_front, fpra_back and the defines header
`timescale 1ns / 1ps
`include "free_page_range_allocator_unit_defines.svh"

module free_page_range_allocator_unit #(
    parameter int unsigned EXTENT_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fpra_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fpra_pkg::t_out_item o_out_item
);

    logic q_valid;
    logic q_take;
    logic busy_clear;
    fpra_pkg::t_in_item q_item;

    fpra_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_stall(o_in_stall),
        .i_item (i_in_item),
        .o_valid(q_valid),
        .i_take (q_take),
        .o_item (q_item)
    );

    fpra_back #(
        .EXTENT_SLOTS(EXTENT_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_take      (q_take),
        .i_item      (q_item),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item),
        .o_busy_clear(busy_clear)
    );

    `FPRA_ASSERT_NEVER(a_take_empty, i_clk, i_rst_n, q_take && !q_valid, "take from empty queue")
    `FPRA_ASSERT_NEVER(a_take_clear, i_clk, i_rst_n, q_take && busy_clear, "take during clearing")
    `FPRA_ASSERT_IMPL(a_no_grant_fail, i_clk, i_rst_n, o_out_valid |-> (o_out_item.status == fpra_pkg::ST_OK || o_out_item.granted_page == '0), "page granted on failure")

endmodule

### hdl/fpra_front.sv
// input stage: register the transaction and queue it
// depends on fpra_pkg
`timescale 1ns / 1ps

module fpra_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fpra_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_take,
    output fpra_pkg::t_in_item  o_item
);

    // two-entry queue
    fpra_pkg::t_in_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic w_push;
    logic w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule

### hdl/fpra_back.sv
// extent table engine: allocate, free and add, one slot per cycle
// depends on fpra_pkg
`timescale 1ns / 1ps

module fpra_back #(
    parameter int unsigned EXTENT_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  fpra_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output fpra_pkg::t_out_item o_item,
    output logic                o_busy_clear
);

    localparam int unsigned IW = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
    localparam int unsigned CW = $clog2(EXTENT_SLOTS + 1);
    localparam int unsigned PB = fpra_pkg::PAGE_NUMBER_BITS;
    localparam int unsigned EW = 2 * PB;
    localparam logic [PB-1:0] PMASK = {PB{1'b1}};
    localparam logic [IW-1:0] TOP = IW'(EXTENT_SLOTS - 1);
    localparam logic [CW-1:0] FULLN = CW'(EXTENT_SLOTS);

    // extent memory: base in upper half, length in lower half
    logic [EW-1:0] r_mem [EXTENT_SLOTS];
    logic [EW-1:0] r_rdata;
    logic [IW-1:0] w_raddr;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;

    fpra_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_used, n_used;
    logic [PB-1:0] r_page, n_page;
    logic [PB-1:0] r_cnt, n_cnt;
    logic [1:0]    r_act, n_act;
    logic          r_hole_ok, n_hole_ok;
    logic [IW-1:0] r_hole, n_hole;
    fpra_pkg::t_out_item r_res, n_res;
    fpra_pkg::t_out_item r_out, n_out;
    logic          r_ovalid, n_ovalid;

    logic [PB-1:0] w_b, w_l;
    logic [PB:0]   w_room;
    logic [PB:0]   w_top;

    assign w_b = r_rdata[EW-1:PB];
    assign w_l = r_rdata[PB-1:0];
    assign w_room = {1'b1, {PB{1'b0}}} - {1'b0, r_page};
    // one past the extent, kept a bit wider so it never wraps to page zero
    assign w_top = {1'b0, w_b} + {1'b0, w_l};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fpra_pkg::S_CLEAR;
            r_idx    <= '0;
            r_cur    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cur    <= n_cur;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_cnt     <= n_cnt;
        r_act     <= n_act;
        r_hole_ok <= n_hole_ok;
        r_hole    <= n_hole;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_valid      = r_ovalid;
    assign o_item       = r_out;
    assign o_busy_clear = (r_state == fpra_pkg::S_CLEAR);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_used    = r_used;
        n_page    = r_page;
        n_cnt     = r_cnt;
        n_act     = r_act;
        n_hole_ok = r_hole_ok;
        n_hole    = r_hole;
        n_res     = r_res;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_stall;
        o_take    = 1'b0;
        w_raddr   = r_idx;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = '0;

        case (r_state)
            fpra_pkg::S_CLEAR: begin
                w_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == TOP) begin
                    n_idx = '0;
                    n_state = fpra_pkg::S_IDLE;
                end
            end
            fpra_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_take    = 1'b1;
                    n_act     = i_item.action;
                    n_page    = i_item.page_number[PB-1:0];
                    n_cnt     = i_item.page_count[PB-1:0];
                    n_hole_ok = 1'b0;
                    n_res     = '0;
                    case (i_item.action)
                        fpra_pkg::ACT_ALLOC: begin
                            w_raddr = r_cur;
                            n_idx   = r_cur;
                            n_state = fpra_pkg::S_ALLOC_CHK;
                        end
                        fpra_pkg::ACT_FREE: begin
                            n_idx = '0;
                            w_raddr = '0;
                            if (r_used == '0) begin
                                n_state = fpra_pkg::S_HOLE_RD;
                            end else begin
                                n_state = fpra_pkg::S_FREE_RD;
                            end
                        end
                        fpra_pkg::ACT_ADD: begin
                            n_state = fpra_pkg::S_ADD;
                        end
                        default: begin
                            n_state = fpra_pkg::S_REPLY;
                        end
                    endcase
                end
            end
            fpra_pkg::S_ALLOC_CHK: begin
                if (w_l != '0) begin
                    n_state = fpra_pkg::S_ALLOC_RD;
                end else if (r_idx != TOP) begin
                    n_idx = r_idx + 1'b1;
                    w_raddr = r_idx + 1'b1;
                    n_hole = r_idx;
                    n_state = fpra_pkg::S_UP_RD;
                end else if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                    w_raddr = r_idx - 1'b1;
                    n_state = fpra_pkg::S_DOWN_RD;
                end else begin
                    n_res.status = fpra_pkg::ST_NO_PAGE;
                    n_state = fpra_pkg::S_REPLY;
                end
            end
            fpra_pkg::S_UP_RD: begin
                // r_hole keeps the start of the search
                if (w_l != '0) begin
                    n_state = fpra_pkg::S_ALLOC_RD;
                end else if (r_idx != TOP) begin
                    n_idx = r_idx + 1'b1;
                    w_raddr = r_idx + 1'b1;
                end else if (r_hole != '0) begin
                    n_idx = r_hole - 1'b1;
                    w_raddr = r_hole - 1'b1;
                    n_state = fpra_pkg::S_DOWN_RD;
                end else begin
                    n_res.status = fpra_pkg::ST_NO_PAGE;
                    n_state = fpra_pkg::S_REPLY;
                end
            end
            fpra_pkg::S_DOWN_RD: begin
                if (w_l != '0) begin
                    n_state = fpra_pkg::S_ALLOC_RD;
                end else if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                    w_raddr = r_idx - 1'b1;
                end else begin
                    n_res.status = fpra_pkg::ST_NO_PAGE;
                    n_state = fpra_pkg::S_REPLY;
                end
            end
            fpra_pkg::S_ALLOC_RD: begin
                // r_rdata still holds the found extent
                n_res.granted_page = fpra_pkg::FIELD_BITS'(w_b);
                n_res.status = fpra_pkg::ST_OK;
                w_we = 1'b1;
                if (w_l > PB'(1)) begin
                    w_wdata = {(w_b + PB'(1)) & PMASK, w_l - PB'(1)};
                    n_cur = r_idx;
                end else begin
                    w_wdata = '0;
                    n_cur = (r_idx != TOP) ? r_idx + 1'b1 : r_idx;
                end
                n_state = fpra_pkg::S_REPLY;
            end
            fpra_pkg::S_FREE_RD: begin
                if (w_l == '0) begin
                    if (!r_hole_ok) begin
                        n_hole_ok = 1'b1;
                        n_hole = r_idx;
                    end
                end
                if (w_l != '0 && w_l != PMASK && {1'b0, r_page} == w_top) begin
                    w_we = 1'b1;
                    w_wdata = {w_b, w_l + PB'(1)};
                    n_state = fpra_pkg::S_REPLY;
                end else if (w_l != '0 && w_l != PMASK && w_b != '0
                             && r_page == w_b - PB'(1)) begin
                    w_we = 1'b1;
                    w_wdata = {w_b - PB'(1), w_l + PB'(1)};
                    n_state = fpra_pkg::S_REPLY;
                end else if (CW'(r_idx) + CW'(1) < r_used) begin
                    n_idx = r_idx + 1'b1;
                    w_raddr = r_idx + 1'b1;
                end else begin
                    n_state = fpra_pkg::S_HOLE_RD;
                end
            end
            fpra_pkg::S_HOLE_RD: begin
                n_state = fpra_pkg::S_REPLY;
                w_wdata = {r_page, PB'(1)};
                if (r_hole_ok) begin
                    w_we = 1'b1;
                    w_waddr = r_hole;
                end else if (r_used >= FULLN) begin
                    n_res.status = fpra_pkg::ST_FULL;
                end else begin
                    w_we = 1'b1;
                    w_waddr = r_used[IW-1:0];
                    n_used = r_used + CW'(1);
                end
            end
            fpra_pkg::S_ADD: begin
                n_state = fpra_pkg::S_REPLY;
                if (r_cnt != '0) begin
                    if (r_used >= FULLN) begin
                        n_res.status = fpra_pkg::ST_FULL;
                    end else begin
                        w_we = 1'b1;
                        w_waddr = r_used[IW-1:0];
                        if ({1'b0, r_cnt} > w_room) begin
                            w_wdata = {r_page, w_room[PB-1:0]};
                        end else begin
                            w_wdata = {r_page, r_cnt};
                        end
                        if (r_page == '0 && r_cnt == PMASK) begin
                            w_wdata = {r_page, PMASK};
                        end
                        n_used = r_used + CW'(1);
                    end
                end
            end
            fpra_pkg::S_REPLY: begin
                // the output register only moves once the previous result has gone
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_out = r_res;
                    n_state = fpra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### dv/free_page_range_allocator_unit_tb.sv
// self-checking testbench for the free page range allocator unit
// depends on fpra_pkg and free_page_range_allocator_unit; predicts each result in-line
`timescale 1ns / 1ps

module free_page_range_allocator_unit_tb;

    localparam int unsigned SLOTS     = 256;
    localparam int unsigned PB        = fpra_pkg::PAGE_NUMBER_BITS;
    localparam logic [PB-1:0] PMASK   = {PB{1'b1}};
    localparam int unsigned IDLE_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    fpra_pkg::t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    fpra_pkg::t_out_item o_out_item;

    free_page_range_allocator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [PB-1:0] ext_base [SLOTS];
    logic [PB-1:0] ext_len  [SLOTS];
    int unsigned   slots_used;
    int unsigned   cur_slot;

    fpra_pkg::t_in_item  pending_items [$];
    fpra_pkg::t_out_item expected_results [$];
    int errors = 0;
    int results_seen = 0;
    int allocs = 0, frees = 0, adds = 0, fulls = 0, nopages = 0;
    bit stimulus_done = 0;
    bit hold_sender = 0;

    function automatic fpra_pkg::t_out_item predict_allocator(fpra_pkg::t_in_item it);
        fpra_pkg::t_out_item r;
        int unsigned c;
        bit found;
        logic [PB:0] room;
        logic [PB-1:0] cnt;
        r = '0;
        r.status = fpra_pkg::ST_OK;
        if (it.action == fpra_pkg::ACT_ALLOC) begin
            c = cur_slot;
            found = 1;
            if (ext_len[c] == 0) begin
                found = 0;
                for (int j = c + 1; j < SLOTS && !found; j++)
                    if (ext_len[j] != 0) begin c = j; found = 1; end
                for (int j = int'(c); j > 0 && !found; j--)
                    if (ext_len[j-1] != 0) begin c = j - 1; found = 1; end
            end
            if (!found) begin
                r.status = fpra_pkg::ST_NO_PAGE;
            end else begin
                r.granted_page = ext_base[c];
                if (ext_len[c] > 1) begin
                    ext_len[c]  = ext_len[c] - 1;
                    ext_base[c] = ext_base[c] + 1;
                    cur_slot = c;
                end else begin
                    ext_len[c] = '0;
                    ext_base[c] = '0;
                    cur_slot = (c + 1 < SLOTS) ? c + 1 : c;
                end
            end
        end else if (it.action == fpra_pkg::ACT_FREE) begin
            found = 0;
            for (int i = 0; i < slots_used && !found; i++) begin
                if (ext_len[i] != 0 && ext_len[i] != PMASK) begin
                    if ({1'b0, it.page_number} == {1'b0, ext_base[i]} + {1'b0, ext_len[i]}) begin
                        ext_len[i] = ext_len[i] + 1;
                        found = 1;
                    end else if (ext_base[i] != 0 && it.page_number == ext_base[i] - 1) begin
                        ext_base[i] = ext_base[i] - 1;
                        ext_len[i] = ext_len[i] + 1;
                        found = 1;
                    end
                end
            end
            for (int i = 0; i < slots_used && !found; i++)
                if (ext_len[i] == 0) begin
                    ext_base[i] = it.page_number;
                    ext_len[i] = 1;
                    found = 1;
                end
            if (!found) begin
                if (slots_used >= SLOTS) r.status = fpra_pkg::ST_FULL;
                else begin
                    ext_base[slots_used] = it.page_number;
                    ext_len[slots_used] = 1;
                    slots_used++;
                end
            end
        end else if (it.action == fpra_pkg::ACT_ADD && it.page_count != 0) begin
            if (slots_used >= SLOTS) r.status = fpra_pkg::ST_FULL;
            else begin
                room = {1'b1, {PB{1'b0}}} - {1'b0, it.page_number};
                cnt = ({1'b0, it.page_count} > room) ? room[PB-1:0] : it.page_count;
                if (room[PB]) cnt = it.page_count;
                ext_base[slots_used] = it.page_number;
                ext_len[slots_used] = cnt;
                slots_used++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [PB-1:0] got, logic [PB-1:0] want);
        $display("mismatch on %s: got 0x%0h expected 0x%0h", what, got, want);
        errors++;
    endtask

    // driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                void'(pending_items.pop_front());
                case (i_in_item.action)
                    fpra_pkg::ACT_ALLOC: allocs++;
                    fpra_pkg::ACT_FREE:  frees++;
                    fpra_pkg::ACT_ADD:   adds++;
                    default:   ;
                endcase
                expected_results.push_back(predict_allocator(i_in_item));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) gap_left--;
                if (hold_sender || gap_left > 0 || pending_items.size() == 0
                        || (i_in_valid && !o_in_stall && pending_items.size() == 0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_items[0];
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern and result checking
    int stall_phase = 0;
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        fpra_pkg::t_out_item want;
        if (i_rst_n) begin
            stall_phase++;
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_item.granted_page, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.granted_page !== want.granted_page)
                        report_mismatch("granted_page", o_out_item.granted_page, want.granted_page);
                    if (o_out_item.status !== want.status)
                        report_mismatch("status", PB'(o_out_item.status), PB'(want.status));
                    if (want.status == fpra_pkg::ST_FULL) fulls++;
                    if (want.status == fpra_pkg::ST_NO_PAGE) nopages++;
                end
            end
            case ((stall_phase / 64) % 4)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= (stall_phase % 3) == 0;
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
                $display("free_page_range_allocator_unit_tb failed");
                $finish;
            end
        end
    end

    function automatic fpra_pkg::t_in_item make_item(logic [1:0] act, logic [PB-1:0] pg,
                                                     logic [PB-1:0] cnt);
        fpra_pkg::t_in_item it;
        it.action = act;
        it.page_number = pg;
        it.page_count = cnt;
        return it;
    endfunction

    function automatic logic [PB-1:0] rand_page();
        logic [PB-1:0] p;
        p = PB'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: p = p & 36'hfff;
            1: p = PMASK - (p & 36'hff);
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [PB-1:0] base;
        int n;
        for (int i = 0; i < SLOTS; i++) begin ext_base[i] = '0; ext_len[i] = '0; end
        slots_used = 0;
        cur_slot = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, merges, clamping, unknown action
        pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, '0, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_ADD, 36'h100, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_ADD, 36'h1000, 36'd2));
        pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, PMASK, PMASK));
        pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, '0, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, '0, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h1000, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h1001, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h0fff, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, '0, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, PMASK, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_ADD, PMASK - 3, PMASK));
        pending_items.push_back(make_item(fpra_pkg::ACT_ADD, '0, PMASK));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h5, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_UNKNOWN, PMASK, PMASK));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, '0, '0));
        wait_drained();

        // hold the sender until every result is back
        hold_sender = 1;
        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        hold_sender = 0;

        // random: allocates, frees often near 0x1000, adds of mostly small regions, unknown actions
        n = 0;
        while (n < 200) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    base = rand_page();
                    pending_items.push_back(make_item(fpra_pkg::ACT_ADD, base,
                        ($urandom_range(0, 7) == 0) ? PMASK : PB'($urandom_range(0, 5))));
                end
                2, 3, 4, 5: pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC,
                    rand_page(), rand_page()));
                6, 7, 8: pending_items.push_back(make_item(fpra_pkg::ACT_FREE,
                    ($urandom_range(0, 1) == 0) ? (36'h1000 + PB'($urandom_range(0, 40)))
                                                : rand_page(),
                    rand_page()));
                default: pending_items.push_back(make_item(fpra_pkg::ACT_UNKNOWN,
                    rand_page(), rand_page()));
            endcase
            n++;
            if (pending_items.size() > 8) wait_drained();
        end

        // fill the table to exercise the full status
        for (int i = 0; i < SLOTS + 4; i++) begin
            pending_items.push_back(make_item(fpra_pkg::ACT_ADD,
                36'h800000000 + PB'(4 * i), 36'd1));
            if (pending_items.size() > 8) wait_drained();
        end
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h7ffffff00, '0));
        for (int i = 0; i < 20; i++)
            pending_items.push_back(make_item(fpra_pkg::ACT_ALLOC, '0, '0));
        pending_items.push_back(make_item(fpra_pkg::ACT_FREE, 36'h7fffffe00, '0));
        wait_drained();
        stimulus_done = 1;

        repeat (2 * SLOTS + 20) @(posedge i_clk);
        $display("covered %0d allocates, %0d frees, %0d region adds; %0d results checked",
                 allocs, frees, adds, results_seen);
        $display("saw %0d table-full and %0d no-page answers", fulls, nopages);
        if (errors == 0 && expected_results.size() == 0)
            $display("free_page_range_allocator_unit_tb passed");
        else
            $display("free_page_range_allocator_unit_tb failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/fpra_pkg.sv
hdl/fpra_front.sv
hdl/fpra_back.sv
hdl/free_page_range_allocator_unit.sv
dv/free_page_range_allocator_unit_tb.sv
